[design/eller_maze_row_generator_core_macros.svh]
// Assertion macros for the Eller maze row generator core.
`ifndef ELLER_MAZE_ROW_GENERATOR_CORE_MACROS_SVH
`define ELLER_MAZE_ROW_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define EMR_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define EMR_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/emr_pkg.sv]
// Shared types and constants of the Eller maze row generator.
`default_nettype none

package emr_pkg;

    localparam int MAX_WIDTH_DEF = 32;        // default cells per row
    localparam int LBL_W         = 6;         // set label width
    localparam int LBL_N         = 1 << LBL_W;
    localparam int CELL_CAP      = 64;        // largest supported row
    localparam int ROW_WIDTH_W   = 6;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 6'd32;

    typedef logic [LBL_W-1:0]    label_t;
    typedef logic [LBL_N-1:0]    label_mask_t;   // one bit per label value
    typedef logic [CELL_CAP-1:0] cell_vec_t;     // one bit per cell position

    typedef struct packed {
        logic [30:0] join_bits;
        logic [31:0] down_bits;
        logic        first_row;
        logic        last_row;
    } row_in_t;

    typedef struct packed {
        logic [30:0] east_walls;
        logic [31:0] south_walls;
    } row_out_t;

    // Alias table control: clear at row start, or record a set merge key -> tgt.
    typedef struct packed {
        logic   clr;
        logic   merge;
        label_t key;
        label_t tgt;
    } alias_cmd_t;

endpackage

`default_nettype wire

[design/emr_label_mem.sv]
// Per-cell set label memory: 1R1W, registered read, reset value = cell index.
`default_nettype none

module emr_label_mem #(
    parameter int DEPTH = emr_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      emr_pkg::label_t          rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire emr_pkg::label_t          wr_data
);

    localparam int AW = $clog2(DEPTH);

    emr_pkg::label_t label_mem [DEPTH];
    emr_pkg::label_t rd_word_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;
    logic [AW-1:0]    rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            label_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= label_mem[rd_addr];
        end
    end

    // written-once flags; an unwritten entry reads as its own index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg  <= vld_reg[rd_addr];
                rd_addr_reg <= rd_addr;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : emr_pkg::label_t'(rd_addr_reg);

endmodule

`default_nettype wire

[design/emr_alias_table.sv]
// Merge alias table: maps a stored label to its current set label within one row.
`default_nettype none

module emr_alias_table #(
    parameter int ENTRIES = emr_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire emr_pkg::alias_cmd_t cmd,
    input  wire emr_pkg::label_t     lk_label,
    output      emr_pkg::label_t     lk_result
);

    localparam int EW = $clog2(ENTRIES);

    emr_pkg::label_t key_reg [ENTRIES];
    emr_pkg::label_t tgt_reg [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    logic [EW-1:0]      cnt_reg;

    // keys are unique (a label dies once per row), so at most one entry hits
    always_comb
    begin
        lk_result = lk_label;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (vld_reg[k] && (key_reg[k] == lk_label))
            begin
                lk_result = tgt_reg[k];
            end
        end
    end

    // merge key -> tgt: retarget every alias that pointed at key, then append
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (cmd.merge && vld_reg[k] && (tgt_reg[k] == cmd.key))
            begin
                tgt_reg[k] <= cmd.tgt;
            end
        end
        if (cmd.merge)
        begin
            key_reg[cnt_reg] <= cmd.key;
            tgt_reg[cnt_reg] <= cmd.tgt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.merge)
        begin
            vld_reg[cnt_reg] <= 1'b1;
            cnt_reg          <= cnt_reg + EW'(1);
        end
    end

endmodule

`default_nettype wire

[design/eller_maze_row_generator_core.sv]
// Top level of the Eller maze row generator: row sequencer, passes and output register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  cfg      | cfg_wr_en                  | cfg_wr_data   row_width (6 bits)
//  in       | in_valid / in_ready        | in_data       join, down, first, last
//  out      | out_valid / out_ready      | out_data      east_walls, south_walls
//
//  W = row_width clamped to [2, MAX_WIDTH].
//  A row runs a join, a down and a fill pass (the last row skips the fill
//  pass): one cell per cycle in each pass, bound by the single read port of
//  the label memory.
//  in_ready is high only between rows; a new row is taken while the previous
//  result still waits on out_ready, and a finished row waits in OUT until the
//  output register is free.
//  Reset clears the label memory's written flags, so every cell reads its own
//  index at once; there is no clearing pass.
`default_nettype none

`include "eller_maze_row_generator_core_macros.svh"

module eller_maze_row_generator_core #(
    parameter int MAX_WIDTH = emr_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [emr_pkg::ROW_WIDTH_W-1:0]     cfg_wr_data,
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire emr_pkg::row_in_t                    in_data,
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      emr_pkg::row_out_t                   out_data
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam logic [6:0] MAX_W7 = 7'(MAX_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_JOIN,
        S_DOWN,
        S_FILL,
        S_OUT
    } state_t;

    // lowest label not yet taken; 63 if all lower ones are
    function automatic emr_pkg::label_t free_label(input emr_pkg::label_mask_t taken);
        emr_pkg::label_t k;
        k = emr_pkg::label_t'(emr_pkg::LBL_N - 1);
        for (int i = emr_pkg::LBL_N - 2; i >= 0; i--)
        begin
            if (!taken[i])
            begin
                k = emr_pkg::label_t'(i);
            end
        end
        return k;
    endfunction

    // ---------------------------------------------------------------- registers
    state_t                          state_reg,     state_next;
    logic [emr_pkg::ROW_WIDTH_W-1:0] row_width_reg, row_width_next;
    logic [IDX_W-1:0]                p_reg,         p_next;      // cell in process
    logic [IDX_W-1:0]                wm1_reg,       wm1_next;    // W-1 of this row
    emr_pkg::row_in_t                row_reg,       row_next;
    emr_pkg::label_t                 prev_reg,      prev_next;   // label of west cell
    emr_pkg::label_mask_t            anydown_reg,   anydown_next; // set has a down bit
    emr_pkg::label_mask_t            seen_reg,      seen_next;   // set met east of here
    emr_pkg::label_mask_t            taken_reg,     taken_next;  // labels in use below
    logic [MAX_WIDTH-1:0]            opened_reg,    opened_next;
    emr_pkg::cell_vec_t              east_reg,      east_next;
    emr_pkg::cell_vec_t              south_reg,     south_next;
    logic                            out_valid_reg, out_valid_next;
    emr_pkg::row_out_t               out_data_reg,  out_data_next;

    // ---------------------------------------------------------------- datapath
    logic                 accept;
    logic [6:0]           w_eff;
    logic [IDX_W-1:0]     wm1_eff;
    emr_pkg::label_t      mem_rd_data;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    emr_pkg::label_t      mem_wr_data;
    emr_pkg::alias_cmd_t  alias_cmd;
    emr_pkg::label_t      orig;        // label as stored before this row
    emr_pkg::label_t      cur;         // label after the merges so far
    emr_pkg::label_t      p_lbl;
    emr_pkg::label_t      i_lbl;
    emr_pkg::cell_vec_t   join_ext;
    emr_pkg::cell_vec_t   down_ext;
    logic                 dn;
    logic                 want;
    logic                 is_merge;
    logic                 is_last;
    logic                 open_dn;
    logic                 p_is_end;
    emr_pkg::label_t      fresh;
    emr_pkg::label_mask_t anydown_mrg;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign w_eff = (row_width_reg < emr_pkg::ROW_WIDTH_W'(2)) ? 7'd2 :
                   ((7'(row_width_reg) > MAX_W7) ? MAX_W7 : 7'(row_width_reg));
    assign wm1_eff = IDX_W'(w_eff - 7'd1);

    assign orig     = row_reg.first_row ? emr_pkg::label_t'(p_reg) : mem_rd_data;
    assign p_lbl    = emr_pkg::label_t'(p_reg);
    assign i_lbl    = p_lbl - emr_pkg::label_t'(1);
    assign join_ext = emr_pkg::cell_vec_t'(row_reg.join_bits);
    assign down_ext = emr_pkg::cell_vec_t'(row_reg.down_bits);
    assign dn       = down_ext[p_lbl];
    assign want     = row_reg.last_row || join_ext[i_lbl];
    assign p_is_end = (p_reg == wm1_reg);
    assign fresh    = free_label(taken_reg);

    // join: differing neighbours with a join bit (any pair on the last row) merge, eastern set takes the western label
    assign is_merge = (state_reg == S_JOIN) && (p_reg != '0) &&
                      (prev_reg != cur) && want;

    // down: a set without any down bit opens below its easternmost cell
    assign is_last = !seen_reg[cur];
    assign open_dn = !row_reg.last_row && (dn || (is_last && !anydown_reg[cur]));

    always_comb
    begin
        anydown_mrg      = anydown_reg;
        anydown_mrg[cur] = anydown_reg[cur] | dn;
        if (is_merge)
        begin
            anydown_mrg[prev_reg] = anydown_mrg[prev_reg] | anydown_mrg[cur];
        end
    end

    emr_label_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_label_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    emr_alias_table #(
        .ENTRIES (MAX_WIDTH)
    ) u_alias_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (alias_cmd),
        .lk_label  (orig),
        .lk_result (cur)
    );

    // ---------------------------------------------------------------- sequencer
    // Join pass reads cells west to east (read of p+1 issued while p is
    // processed). Down pass reads east to west and writes back the merged
    // label of the cell just read. Fill pass only writes. A cell is never read
    // and written in the same cycle, so the memory needs no bypass.
    always_comb
    begin
        state_next     = state_reg;
        row_width_next = row_width_reg;
        p_next         = p_reg;
        wm1_next       = wm1_reg;
        row_next       = row_reg;
        prev_next      = prev_reg;
        anydown_next   = anydown_reg;
        seen_next      = seen_reg;
        taken_next     = taken_reg;
        opened_next    = opened_reg;
        east_next      = east_reg;
        south_next     = south_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = p_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = p_reg;
        mem_wr_data    = cur;
        alias_cmd      = '0;

        if (cfg_wr_en)
        begin
            row_width_next = cfg_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_next      = in_data;
                    wm1_next      = wm1_eff;
                    p_next        = '0;
                    anydown_next  = '0;
                    seen_next     = '0;
                    taken_next    = '0;
                    east_next     = '1;
                    south_next    = '1;
                    alias_cmd.clr = 1'b1;
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = '0;
                    state_next    = S_JOIN;
                end
            end

            S_JOIN:
            begin
                anydown_next = anydown_mrg;
                if (is_merge)
                begin
                    east_next[i_lbl] = 1'b0;
                    alias_cmd.merge  = 1'b1;
                    alias_cmd.key    = cur;
                    alias_cmd.tgt    = prev_reg;
                end
                else
                begin
                    prev_next = cur;
                end
                mem_rd_en = 1'b1;
                if (p_is_end)
                begin
                    mem_rd_addr = p_reg;          // first cell of the down pass
                    state_next  = S_DOWN;
                end
                else
                begin
                    mem_rd_addr = p_reg + IDX_W'(1);
                    p_next      = p_reg + IDX_W'(1);
                end
            end

            S_DOWN:
            begin
                seen_next[cur]     = 1'b1;
                opened_next[p_reg] = open_dn;
                mem_wr_en          = 1'b1;
                mem_wr_data        = cur;
                if (open_dn)
                begin
                    taken_next[cur]   = 1'b1;
                    south_next[p_lbl] = 1'b0;
                end
                if (p_reg == '0)
                begin
                    state_next = row_reg.last_row ? S_OUT : S_FILL;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = p_reg - IDX_W'(1);
                    p_next      = p_reg - IDX_W'(1);
                end
            end

            S_FILL:
            begin
                // cells with no passage south start a new set
                if (!opened_reg[p_reg])
                begin
                    mem_wr_en         = 1'b1;
                    mem_wr_data       = fresh;
                    taken_next[fresh] = 1'b1;
                end
                if (p_is_end)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    p_next = p_reg + IDX_W'(1);
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.east_walls  = east_reg[30:0];
                    out_data_next.south_walls = south_reg[31:0];
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_width_reg <= emr_pkg::ROW_WIDTH_RST;
            p_reg         <= '0;
            wm1_reg       <= '0;
            row_reg       <= '0;
            prev_reg      <= '0;
            anydown_reg   <= '0;
            seen_reg      <= '0;
            taken_reg     <= '0;
            opened_reg    <= '0;
            east_reg      <= '1;
            south_reg     <= '1;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_width_reg <= row_width_next;
            p_reg         <= p_next;
            wm1_reg       <= wm1_next;
            row_reg       <= row_next;
            prev_reg      <= prev_next;
            anydown_reg   <= anydown_next;
            seen_reg      <= seen_next;
            taken_reg     <= taken_next;
            opened_reg    <= opened_next;
            east_reg      <= east_next;
            south_reg     <= south_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------------------------------------------------------- checks
    `EMR_ASSERT_NOW(a_mem_no_rw_same_cell, clk, rst_n, mem_rd_en && mem_wr_en, mem_rd_addr != mem_wr_addr, "label memory read and written at the same cell")
    `EMR_ASSERT_NOW(a_fresh_label_free, clk, rst_n, (state_reg == S_FILL) && mem_wr_en, !taken_reg[fresh], "fresh label already in use")
    `EMR_ASSERT_NEXT(a_out_load, clk, rst_n, (state_reg == S_OUT) && (!out_valid_reg || out_ready), out_valid && in_ready, "finished row not presented")

endmodule

`default_nettype wire

[tb/eller_maze_row_generator_core_test.sv]
// Self-checking testbench for the Eller maze row generator core.
module eller_maze_row_generator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import emr_pkg::*;

    // Row width register is 6 bits, but at most this many cells are ever in use.
    localparam int CELLS         = MAX_WIDTH_DEF;
    // Idle time before a register write and before the final verdict; longer than
    // a full-width row takes.
    localparam int SETTLE_CYCLES = 3 * CELLS + 16;
    // Length of a deliberate output hold-off, long enough to back the core up.
    localparam int LONG_HOLD     = 500;
    localparam int RANDOM_ROWS   = 1500;

    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     cfg_wr_en   = 1'b0;
    logic [ROW_WIDTH_W-1:0] cfg_wr_data = '0;
    logic     in_valid    = 1'b0;
    logic     in_ready;
    row_in_t  in_data     = '0;
    logic     out_valid;
    logic     out_ready   = 1'b0;
    row_out_t out_data;

    eller_maze_row_generator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Row predictor state: a private copy of the row width register and of
    // the per-cell set labels. Only cells below the clamped width are
    // touched, so labels past the width survive a width change.
    // ------------------------------------------------------------------
    logic [ROW_WIDTH_W-1:0] width_reg;
    label_t                 cell_lbl [CELLS];

    row_in_t  pending_rows [$];   // rows waiting for the driver
    row_out_t walls_due    [$];   // predicted walls, oldest first

    int fail_count   = 0;
    int rows_taken   = 0;
    int results_seen = 0;

    // Walls of one row; advances the label state exactly as the core should.
    function automatic row_out_t build_row_walls(row_in_t r);
        int          w;
        int          i;
        int          j;
        int          k;
        label_t      a;
        label_t      b;
        label_t      s;
        logic [31:0] east;
        logic [31:0] south;
        logic [63:0] set_used;
        logic [63:0] taken;
        logic [31:0] open_dn;
        logic        is_last;
        row_out_t    res;

        // Out-of-range widths are clamped to [2, CELLS].
        w = int'(width_reg);
        if (w < 2)
            w = 2;
        if (w > CELLS)
            w = CELLS;
        east  = '1;
        south = '1;

        if (r.first_row)
            for (i = 0; i < w; i++)
                cell_lbl[i] = label_t'(i);

        // Join pass, west to east: the eastern set takes the western label.
        // On the last row every differing pair joins.
        for (i = 0; i + 1 < w; i++)
        begin
            a = cell_lbl[i];
            b = cell_lbl[i+1];
            if (a != b && (r.last_row || r.join_bits[i]))
            begin
                for (j = 0; j < w; j++)
                    if (cell_lbl[j] == b)
                        cell_lbl[j] = a;
                east[i] = 1'b0;
            end
        end

        // Last row opens nothing downward and keeps its merged labels.
        if (!r.last_row)
        begin
            set_used = '0;
            taken    = '0;
            open_dn  = '0;
            // Down pass: optional openings, plus a forced one at the last cell
            // of any set that has none yet.
            for (i = 0; i < w; i++)
            begin
                s       = cell_lbl[i];
                is_last = 1'b1;
                for (j = i + 1; j < w; j++)
                    if (cell_lbl[j] == s)
                        is_last = 1'b0;
                open_dn[i] = r.down_bits[i] || (is_last && !set_used[s]);
                if (open_dn[i])
                begin
                    set_used[s] = 1'b1;
                    south[i]    = 1'b0;
                end
            end
            // Cells not carried down take the smallest free label, west first.
            for (i = 0; i < w; i++)
                if (open_dn[i])
                    taken[cell_lbl[i]] = 1'b1;
            for (i = 0; i < w; i++)
                if (!open_dn[i])
                begin
                    k = 0;
                    while (k < 63 && taken[k])
                        k++;
                    cell_lbl[i] = label_t'(k);
                    taken[k]    = 1'b1;
                end
        end

        res.east_walls  = east[30:0];
        res.south_walls = south;
        return res;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bit patterns for join and down masks, from empty through sparse and
    // dense to full, so both forced and optional openings get exercised.
    function automatic logic [31:0] rand_bits();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom & $urandom & $urandom;
            3: return $urandom | $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_row(logic first, logic last,
                                      logic [31:0] join_m, logic [31:0] down_m);
        row_in_t r;
        r.join_bits = join_m[30:0];
        r.down_bits = down_m;
        r.first_row = first;
        r.last_row  = last;
        pending_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes rows off pending_rows, keeps valid and payload steady
    // until the transaction completes, and predicts the walls at acceptance.
    // ------------------------------------------------------------------
    int send_gap = 0;
    int tx_gap;
    bit tx_calm  = 1'b0;   // stretch with no sender idling

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                // in_data still holds the row just accepted.
                walls_due.push_back(build_row_walls(in_data));
                rows_taken++;
                if ($urandom_range(0, 99) == 0)
                    tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : pick_gap();
            end
            else
                tx_gap = send_gap;

            if (tx_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= tx_gap - 1;
            end
            else if (pending_rows.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_rows.pop_front();
                send_gap <= 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every result transaction against the oldest
    // prediction and paces out_ready. At most twice per run it holds off
    // for a long stretch while rows are still queued, so the core backs up
    // and drops in_ready.
    // ------------------------------------------------------------------
    row_out_t exp_walls;
    int       stall_left = 0;
    int       hold_left  = 0;
    int       holds_done = 0;
    int       hold_after = 100;
    int       rx_gap;
    bit       rx_calm    = 1'b0;   // stretch with out_ready held high

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (walls_due.size() == 0)
                begin
                    $error("result with no row outstanding: east_walls=%h south_walls=%h",
                           out_data.east_walls, out_data.south_walls);
                    fail_count++;
                end
                else
                begin
                    exp_walls = walls_due.pop_front();
                    if (out_data.east_walls !== exp_walls.east_walls)
                    begin
                        $error("east_walls mismatch: expected %h, actual %h",
                               exp_walls.east_walls, out_data.east_walls);
                        fail_count++;
                    end
                    if (out_data.south_walls !== exp_walls.south_walls)
                    begin
                        $error("south_walls mismatch: expected %h, actual %h",
                               exp_walls.south_walls, out_data.south_walls);
                        fail_count++;
                    end
                end
            end

            if ($urandom_range(0, 149) == 0)
                rx_calm = !rx_calm;

            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (holds_done < 2 && results_seen >= hold_after &&
                     pending_rows.size() > 8)
            begin
                out_ready  <= 1'b0;
                hold_left  <= LONG_HOLD;
                holds_done++;
                hold_after = results_seen + 600;
            end
            else if (stall_left != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (rx_calm)
                out_ready <= 1'b1;
            else
            begin
                rx_gap = pick_gap();
                if (rx_gap == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready  <= 1'b0;
                    stall_left <= rx_gap - 1;
                end
            end
        end
    end

    // Wait for every queued row to go through and the core to fall quiet.
    task automatic wait_idle();
        while (pending_rows.size() != 0 || in_valid || walls_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Row width write; the predictor follows once the edge has taken it.
    task automatic set_row_width(input logic [ROW_WIDTH_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        width_reg = value;
    endtask

    // Widths forced early on: clamped low, clamped high, smallest, near full.
    logic [ROW_WIDTH_W-1:0] early_widths [6] = '{6'd0, 6'd63, 6'd1, 6'd33, 6'd31, 6'd3};

    // ------------------------------------------------------------------
    // Stimulus sequencer
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        int phase;
        int phase_rows;
        int queued;
        int middle;
        int mazes;
        int noise_rows;
        int random_rows;
        bit fresh_start;
        logic [ROW_WIDTH_W-1:0] w;

        phase       = 0;
        mazes       = 0;
        noise_rows  = 0;
        random_rows = 0;

        width_reg = ROW_WIDTH_RST;
        for (i = 0; i < CELLS; i++)
            cell_lbl[i] = label_t'(i);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at the reset width of 32. The first one runs on the
        // reset labels without first_row.
        queue_row(1'b0, 1'b0, 32'h0,        32'h0);         // every set forced down
        queue_row(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0);        // one set, one forced down
        queue_row(1'b0, 1'b0, 32'h0,        32'hFFFF_FFFF); // all optional downs
        queue_row(1'b0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_row(1'b0, 1'b0, 32'h2AAA_AAAA, 32'h5555_5555);
        queue_row(1'b0, 1'b1, 32'h0,        32'hFFFF_FFFF); // last row joins all
        queue_row(1'b0, 1'b1, 32'h0,        32'h0);         // merged labels kept: no joins
        queue_row(1'b0, 1'b0, 32'h0,        32'h0);         // after last row without first
        queue_row(1'b1, 1'b1, 32'h0,        32'h0);         // first and last together
        queue_row(1'b1, 1'b0, 32'h4000_0001, 32'h8000_0001);
        queue_row(1'b0, 1'b0, 32'h7FFF_FFFE, 32'h0000_0001);
        queue_row(1'b0, 1'b0, 32'h0000_FFFF, 32'hFFFF_0000);
        queue_row(1'b0, 1'b0, $urandom,     $urandom);
        queue_row(1'b0, 1'b1, $urandom,     $urandom);
        wait_idle();

        // Smallest row: unused wall bits must all read 1.
        set_row_width(6'd2);
        queue_row(1'b1, 1'b0, 32'h0, 32'h0);
        queue_row(1'b0, 1'b0, 32'h1, 32'h3);
        queue_row(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h2);
        queue_row(1'b0, 1'b1, 32'h0, 32'h0);
        queue_row(1'b1, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // Random phases, each at its own width. A phase may start without
        // first_row so stale labels from the previous width come into play.
        while (random_rows < RANDOM_ROWS)
        begin
            w = (phase < 6) ? early_widths[phase] : 6'($urandom_range(0, 63));
            phase++;
            set_row_width(w);
            phase_rows  = $urandom_range(60, 140);
            queued      = 0;
            fresh_start = ($urandom_range(0, 9) >= 3);
            while (queued < phase_rows)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // Well-formed maze: first row, body rows, closing row.
                    middle = $urandom_range(0, 10);
                    queue_row(fresh_start, 1'b0, rand_bits(), rand_bits());
                    for (i = 0; i < middle; i++)
                        queue_row(1'b0, 1'b0, rand_bits(), rand_bits());
                    queue_row(1'b0, 1'b1, rand_bits(), rand_bits());
                    queued += middle + 2;
                    mazes++;
                end
                else
                begin
                    // Noise: flags in any combination.
                    queue_row(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              rand_bits(), rand_bits());
                    queued++;
                    noise_rows++;
                end
                fresh_start = 1'b1;
            end
            random_rows += queued;
            wait_idle();
        end

        if (walls_due.size() != 0)
        begin
            $error("%0d predicted rows never came out", walls_due.size());
            fail_count++;
        end

        $display("Rows sent %0d, results checked %0d over %0d width phases",
                 rows_taken, results_seen, phase + 2);
        $display("Random part: %0d complete mazes, %0d loose rows, %0d long output hold-offs",
                 mazes, noise_rows, holds_done);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
